// File: rtl/core/svne_pkg.sv
// ----------------------------------------------------------------------------
// svne_pkg
// Shared types, codes and constants of the smooth vertex normal engine.
// ----------------------------------------------------------------------------
package svne_pkg;

    localparam int SVNE_VERTEX_DEPTH = 1024;
    localparam int SVNE_COORD_BITS   = 16;

    localparam int ACC_W   = 48;
    localparam int OUT_W   = 16;
    localparam int FIELD_W = 16;
    localparam int IDX_W   = 10;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [OUT_W-1:0]        ONE_Q14 = 16'd16384;

    // s_tdata layout
    localparam int S_TDATA_W = 88;
    localparam int OFS_VIDX  = 0;
    localparam int OFS_PX    = 10;
    localparam int OFS_PY    = 26;
    localparam int OFS_PZ    = 42;
    localparam int OFS_CA    = 58;
    localparam int OFS_CB    = 68;
    localparam int OFS_CC    = 78;
    localparam int M_TDATA_W = 48;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_TRI   = 2'd1,
        MODE_READ  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_BAD  = 2'd1,
        STAT_ZERO = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_TRI_RD,
        ST_TRI_CAP,
        ST_TRI_DIFF,
        ST_TRI_MUL,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_RD_ISSUE,
        ST_RD_CHK,
        ST_NORM,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        NS_IDLE,
        NS_MAG,
        NS_SHIFT,
        NS_SQ,
        NS_SQRT,
        NS_DIV_LD,
        NS_DIV,
        NS_DONE
    } nstate_t;

    typedef struct packed {
        logic                    done;
        logic                    zero;
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } norm_res_t;

endpackage

// File: rtl/core/svne_ram.sv
// ----------------------------------------------------------------------------
// svne_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module svne_ram
    import svne_pkg::*;
#(
    parameter int WIDTH = 48,
    parameter int DEPTH = SVNE_VERTEX_DEPTH
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/svne_norm.sv
// ----------------------------------------------------------------------------
// svne_norm
// Iterative normalizer: scale to [2^29, 2^30), sum of squares, bit-serial
// square root and restoring divide, one component at a time.
// ----------------------------------------------------------------------------
module svne_norm
    import svne_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] cx,
    input  logic signed [ACC_W-1:0] cy,
    input  logic signed [ACC_W-1:0] cz,
    output norm_res_t               res
);

    localparam logic [ACC_W-1:0] M_HI = 48'h0000_4000_0000;
    localparam logic [ACC_W-1:0] M_LO = 48'h0000_2000_0000;

    nstate_t state_reg, state_next;

    logic [ACC_W-1:0]  mag_reg [3];
    logic [2:0]        neg_reg;
    logic [ACC_W-1:0]  m_reg;
    logic [1:0]        k_reg;
    logic [59:0]       sq_reg;
    logic [61:0]       sum_reg;
    logic [61:0]       rn_reg;
    logic [61:0]       root_reg;
    logic [61:0]       bit_reg;
    logic [45:0]       num_reg;
    logic [30:0]       rem_reg;
    logic [15:0]       q_reg;
    logic [4:0]        dcnt_reg;
    logic signed [OUT_W-1:0] out_reg [3];
    logic              zero_reg;

    logic [30:0] len;
    logic [31:0] rem2;
    logic [15:0] q_done;
    logic [15:0] q_clamp;
    logic [61:0] trial;

    assign len    = root_reg[30:0];
    assign rem2   = {rem_reg, num_reg[dcnt_reg[3:0]]};
    assign trial  = root_reg + bit_reg;
    assign q_done = q_reg;
    assign q_clamp = (q_done > ONE_Q14) ? ONE_Q14 : q_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= NS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            NS_IDLE:   if (start) state_next = NS_MAG;
            NS_MAG:    state_next = NS_SHIFT;
            NS_SHIFT: begin
                if (m_reg == '0) begin
                    state_next = NS_DONE;
                end else if (m_reg < M_HI && m_reg >= M_LO) begin
                    state_next = NS_SQ;
                end
            end
            NS_SQ:     if (k_reg == 2'd3) state_next = NS_SQRT;
            NS_SQRT:   if (bit_reg == '0) state_next = NS_DIV_LD;
            NS_DIV_LD: state_next = NS_DIV;
            NS_DIV: begin
                if (dcnt_reg == 5'd0) begin
                    state_next = (k_reg == 2'd2) ? NS_DONE : NS_DIV_LD;
                end
            end
            NS_DONE:   state_next = NS_IDLE;
            default:   state_next = NS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            NS_IDLE: begin
                if (start) begin
                    mag_reg[0] <= cx[ACC_W-1] ? ACC_W'(-cx) : ACC_W'(cx);
                    mag_reg[1] <= cy[ACC_W-1] ? ACC_W'(-cy) : ACC_W'(cy);
                    mag_reg[2] <= cz[ACC_W-1] ? ACC_W'(-cz) : ACC_W'(cz);
                    neg_reg    <= {cz[ACC_W-1], cy[ACC_W-1], cx[ACC_W-1]};
                    zero_reg   <= 1'b0;
                    out_reg[0] <= '0;
                    out_reg[1] <= '0;
                    out_reg[2] <= '0;
                end
            end
            NS_MAG: begin
                if (mag_reg[0] >= mag_reg[1] && mag_reg[0] >= mag_reg[2]) begin
                    m_reg <= mag_reg[0];
                end else if (mag_reg[1] >= mag_reg[2]) begin
                    m_reg <= mag_reg[1];
                end else begin
                    m_reg <= mag_reg[2];
                end
                k_reg   <= '0;
                sum_reg <= '0;
            end
            NS_SHIFT: begin
                if (m_reg == '0) begin
                    zero_reg <= 1'b1;
                end else if (m_reg >= M_HI) begin
                    m_reg      <= m_reg >> 1;
                    mag_reg[0] <= mag_reg[0] >> 1;
                    mag_reg[1] <= mag_reg[1] >> 1;
                    mag_reg[2] <= mag_reg[2] >> 1;
                end else if (m_reg < M_LO) begin
                    m_reg      <= m_reg << 1;
                    mag_reg[0] <= mag_reg[0] << 1;
                    mag_reg[1] <= mag_reg[1] << 1;
                    mag_reg[2] <= mag_reg[2] << 1;
                end
            end
            NS_SQ: begin
                // one square per cycle, summed in the following cycle
                if (k_reg != 2'd3) begin
                    sq_reg <= mag_reg[k_reg][29:0] * mag_reg[k_reg][29:0];
                end
                if (k_reg != 2'd0) begin
                    sum_reg <= sum_reg + 62'(sq_reg);
                end
                if (k_reg == 2'd3) begin
                    rn_reg   <= sum_reg + 62'(sq_reg);
                    root_reg <= '0;
                    bit_reg  <= 62'(1) << 60;
                    k_reg    <= '0;
                end else begin
                    k_reg <= k_reg + 2'd1;
                end
            end
            NS_SQRT: begin
                if (bit_reg != '0) begin
                    if (rn_reg >= trial) begin
                        rn_reg   <= rn_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            end
            NS_DIV_LD: begin
                num_reg  <= {2'b00, mag_reg[k_reg][29:0], 14'd0} + 46'(len >> 1);
                rem_reg  <= 31'((({2'b00, mag_reg[k_reg][29:0], 14'd0}
                            + 46'(len >> 1)) >> 16));
                q_reg    <= '0;
                dcnt_reg <= 5'd15;
            end
            NS_DIV: begin
                if (rem2 >= {1'b0, len}) begin
                    rem_reg <= 31'(rem2 - {1'b0, len});
                    q_reg   <= {q_reg[14:0], 1'b1};
                end else begin
                    rem_reg <= rem2[30:0];
                    q_reg   <= {q_reg[14:0], 1'b0};
                end
                if (dcnt_reg == 5'd0) begin
                    k_reg <= k_reg + 2'd1;
                end else begin
                    dcnt_reg <= dcnt_reg - 5'd1;
                end
            end
            NS_DONE: begin
            end
            default: begin
            end
        endcase
        // final quotient bit lands at the last divide step; apply sign next cycle
        if (state_reg == NS_DIV_LD && k_reg != 2'd0) begin
            out_reg[k_reg - 2'd1] <= neg_reg[k_reg - 2'd1] ? -$signed(q_clamp)
                                                           : $signed(q_clamp);
        end
        if (state_reg == NS_DONE && !zero_reg) begin
            out_reg[2] <= neg_reg[2] ? -$signed(q_clamp) : $signed(q_clamp);
        end
    end

    always_comb begin
        res.done = (state_reg == NS_DONE);
        res.zero = zero_reg;
        res.x    = out_reg[0];
        res.y    = out_reg[1];
        res.z    = (state_reg == NS_DONE && !zero_reg)
                   ? (neg_reg[2] ? -$signed(q_clamp) : $signed(q_clamp))
                   : out_reg[2];
    end

endmodule

// File: rtl/core/smooth_vertex_normal_engine_top.sv
// ----------------------------------------------------------------------------
// smooth_vertex_normal_engine_top
// Per-vertex area-weighted normal accumulation and normalized readback.
// ----------------------------------------------------------------------------
//  channel   direction  tdata                                 tuser
//  s_        in         slot,pos_x/y/z,corner_a/b/c           mode
//  m_        out        normal_x, normal_y, normal_z          status
//
//  One item at a time. Vertex write: a single position-RAM write. Triangle:
//  six position-RAM read steps, seven steps on one shared multiplier, three
//  accumulator read-modify-writes. Read: runs the normalizer (shift search,
//  31-step square root, three 16-step divides). Clear: a sweep of both RAMs;
//  after reset the same sweep runs with s_tready low.
//  A finished result waits in the output register; the next item is accepted
//  meanwhile and stalls only when its own result is ready.
// ----------------------------------------------------------------------------
module smooth_vertex_normal_engine_top
    import svne_pkg::*;
#(
    parameter int VERTEX_DEPTH = SVNE_VERTEX_DEPTH,
    parameter int COORD_BITS   = SVNE_COORD_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // slot, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // normal_x, normal_y, normal_z
    output logic [M_TDATA_W-1:0] m_tdata,
    // status
    output logic [1:0]           m_tuser
);

    localparam int IW   = $clog2(VERTEX_DEPTH);
    localparam int CB   = COORD_BITS;
    localparam int DW   = CB + 1;
    localparam int PW   = 2 * DW;
    localparam int NW   = PW + 1;
    localparam int SW   = ((NW > ACC_W) ? NW : ACC_W) + 1;
    localparam int POSW = 3 * CB + 1;
    localparam int ACCW = 3 * ACC_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(VERTEX_DEPTH - 1);

    function automatic logic f_in_range(input logic [IDX_W-1:0] v);
        return 32'(v) < 32'(VERTEX_DEPTH);
    endfunction

    function automatic logic [IW-1:0] f_idx(input logic [IDX_W-1:0] v);
        return IW'(v);
    endfunction

    function automatic logic signed [ACC_W-1:0] f_sat(
        input logic signed [ACC_W-1:0] a,
        input logic signed [NW-1:0]    b
    );
        logic signed [SW-1:0] s;
        s = SW'(a) + SW'(b);
        if (s > SW'(ACC_MAX)) begin
            return ACC_MAX;
        end else if (s < SW'(ACC_MIN)) begin
            return ACC_MIN;
        end
        return ACC_W'(s);
    endfunction

    state_t state_reg, state_next;

    logic              s_acc;
    mode_t             in_mode;
    logic [IDX_W-1:0]  in_vidx;

    logic [IDX_W-1:0]  vidx_reg;
    logic [IDX_W-1:0]  corner_reg [3];
    logic [1:0]        k_reg;
    logic [2:0]        j_reg;
    logic [IW-1:0]     sweep_reg;
    logic              bad_reg;
    logic [3*CB-1:0]   p_reg [3];
    logic signed [DW-1:0] u_reg [3];
    logic signed [DW-1:0] w_reg [3];
    logic signed [PW-1:0] prod_reg;
    logic signed [NW-1:0] n_reg [3];
    status_t           res_status_reg;
    logic [M_TDATA_W-1:0] res_data_reg;
    logic              m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    status_t           m_status_reg;

    logic              pos_we;
    logic [IW-1:0]     pos_waddr;
    logic [POSW-1:0]   pos_wdata;
    logic [IW-1:0]     pos_raddr;
    logic [POSW-1:0]   pos_rdata;
    logic              acc_we;
    logic [IW-1:0]     acc_waddr;
    logic [ACCW-1:0]   acc_wdata;
    logic [IW-1:0]     acc_raddr;
    logic [ACCW-1:0]   acc_rdata;

    logic              norm_start;
    norm_res_t         norm_res;
    logic              bad_now;
    logic              out_free;
    logic signed [DW-1:0] mul_a, mul_b;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign in_mode  = mode_t'(s_tuser);
    assign in_vidx  = s_tdata[OFS_VIDX +: IDX_W];
    assign out_free = !m_tvalid_reg || m_tready;
    assign bad_now  = bad_reg || !f_in_range(corner_reg[k_reg]) || !pos_rdata[3*CB];

    // position RAM: {valid, z, y, x}
    svne_ram #(.WIDTH(POSW), .DEPTH(VERTEX_DEPTH)) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    // accumulator RAM: {z, y, x}
    svne_ram #(.WIDTH(ACCW), .DEPTH(VERTEX_DEPTH)) u_acc_ram (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    svne_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .cx      ($signed(acc_rdata[0 +: ACC_W])),
        .cy      ($signed(acc_rdata[ACC_W +: ACC_W])),
        .cz      ($signed(acc_rdata[2*ACC_W +: ACC_W])),
        .res     (norm_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pos_we     = 1'b0;
        pos_waddr  = sweep_reg;
        pos_wdata  = '0;
        acc_we     = 1'b0;
        acc_waddr  = sweep_reg;
        acc_wdata  = '0;
        pos_raddr  = (state_reg == ST_RD_ISSUE) ? f_idx(vidx_reg) : f_idx(corner_reg[k_reg]);
        acc_raddr  = pos_raddr;
        norm_start = 1'b0;
        unique case (state_reg)
            ST_INIT, ST_CLEAR: begin
                pos_we = 1'b1;
                acc_we = 1'b1;
                if (sweep_reg == LAST_IDX) begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    unique case (in_mode)
                        MODE_WRITE: begin
                            pos_we     = f_in_range(in_vidx);
                            pos_waddr  = f_idx(in_vidx);
                            pos_wdata  = {1'b1,
                                          CB'(s_tdata[OFS_PZ +: FIELD_W]),
                                          CB'(s_tdata[OFS_PY +: FIELD_W]),
                                          CB'(s_tdata[OFS_PX +: FIELD_W])};
                            state_next = ST_DONE;
                        end
                        MODE_TRI:   state_next = ST_TRI_RD;
                        MODE_READ:  state_next = ST_RD_ISSUE;
                        MODE_CLEAR: state_next = ST_CLEAR;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_TRI_RD:   state_next = ST_TRI_CAP;
            ST_TRI_CAP: begin
                if (k_reg == 2'd2) begin
                    state_next = bad_now ? ST_DONE : ST_TRI_DIFF;
                end else begin
                    state_next = ST_TRI_RD;
                end
            end
            ST_TRI_DIFF: state_next = ST_TRI_MUL;
            ST_TRI_MUL:  if (j_reg == 3'd6) state_next = ST_ACC_RD;
            ST_ACC_RD:   state_next = ST_ACC_WR;
            ST_ACC_WR: begin
                acc_we    = 1'b1;
                acc_waddr = f_idx(corner_reg[k_reg]);
                acc_wdata = {f_sat($signed(acc_rdata[2*ACC_W +: ACC_W]), n_reg[2]),
                             f_sat($signed(acc_rdata[ACC_W +: ACC_W]), n_reg[1]),
                             f_sat($signed(acc_rdata[0 +: ACC_W]), n_reg[0])};
                state_next = (k_reg == 2'd2) ? ST_DONE : ST_ACC_RD;
            end
            ST_RD_ISSUE: state_next = ST_RD_CHK;
            ST_RD_CHK: begin
                if (!f_in_range(vidx_reg) || !pos_rdata[3*CB]) begin
                    state_next = ST_DONE;
                end else begin
                    norm_start = 1'b1;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:     if (norm_res.done) state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // cross product operand select for the shared multiplier
    always_comb begin
        unique case (j_reg)
            3'd0:    begin mul_a = u_reg[1]; mul_b = w_reg[2]; end
            3'd1:    begin mul_a = u_reg[2]; mul_b = w_reg[1]; end
            3'd2:    begin mul_a = u_reg[2]; mul_b = w_reg[0]; end
            3'd3:    begin mul_a = u_reg[0]; mul_b = w_reg[2]; end
            3'd4:    begin mul_a = u_reg[0]; mul_b = w_reg[1]; end
            3'd5:    begin mul_a = u_reg[1]; mul_b = w_reg[0]; end
            default: begin mul_a = '0;       mul_b = '0;       end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_INIT, ST_CLEAR: begin
                    sweep_reg <= sweep_reg + IW'(1);
                end
                ST_IDLE: begin
                    sweep_reg <= '0;
                    if (s_acc) begin
                        vidx_reg       <= in_vidx;
                        corner_reg[0]  <= s_tdata[OFS_CA +: IDX_W];
                        corner_reg[1]  <= s_tdata[OFS_CB +: IDX_W];
                        corner_reg[2]  <= s_tdata[OFS_CC +: IDX_W];
                        k_reg          <= '0;
                        bad_reg        <= 1'b0;
                        res_data_reg   <= '0;
                        res_status_reg <= (in_mode == MODE_WRITE && !f_in_range(in_vidx))
                                          ? STAT_BAD : STAT_OK;
                    end
                end
                ST_TRI_CAP: begin
                    p_reg[k_reg] <= pos_rdata[3*CB-1:0];
                    bad_reg      <= bad_now;
                    if (k_reg == 2'd2) begin
                        k_reg <= '0;
                        if (bad_now) res_status_reg <= STAT_BAD;
                    end else begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
                ST_TRI_DIFF: begin
                    for (int i = 0; i < 3; i++) begin
                        u_reg[i] <= DW'($signed(p_reg[1][i*CB +: CB]))
                                  - DW'($signed(p_reg[0][i*CB +: CB]));
                        w_reg[i] <= DW'($signed(p_reg[2][i*CB +: CB]))
                                  - DW'($signed(p_reg[0][i*CB +: CB]));
                    end
                    j_reg <= '0;
                end
                ST_TRI_MUL: begin
                    prod_reg <= mul_a * mul_b;
                    // even products start a component, odd ones are subtracted
                    if (j_reg != 3'd0) begin
                        if (j_reg[0]) begin
                            n_reg[2'((j_reg - 3'd1) >> 1)] <= NW'(prod_reg);
                        end else begin
                            n_reg[2'((j_reg - 3'd1) >> 1)] <= n_reg[2'((j_reg - 3'd1) >> 1)]
                                                             - NW'(prod_reg);
                        end
                    end
                    j_reg <= j_reg + 3'd1;
                end
                ST_ACC_WR: begin
                    k_reg <= k_reg + 2'd1;
                end
                ST_RD_CHK: begin
                    if (!f_in_range(vidx_reg) || !pos_rdata[3*CB]) begin
                        res_status_reg <= STAT_BAD;
                    end
                end
                ST_NORM: begin
                    if (norm_res.done) begin
                        if (norm_res.zero) begin
                            res_status_reg <= STAT_ZERO;
                        end else begin
                            res_data_reg <= {norm_res.z, norm_res.y, norm_res.x};
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg  <= res_data_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_status_reg;

endmodule
